FILE: rtl/segi_pkg.sv
// Shared constants and types for the segment intersection pipeline.
// No dependencies.
package segi_pkg;

    localparam int CW    = 16;               // coordinate width, Q12.4
    localparam int DW    = CW + 1;           // difference width
    localparam int PW    = 2 * DW;           // product width
    localparam int SW    = PW + 1;           // cross-product sum width, signed
    localparam int UW    = PW + 1;           // normalised magnitude width
    localparam int QB    = CW;               // quotient bits
    localparam int NW    = UW + QB;          // scaled numerator width
    localparam int IN_W  = ((8 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 7) / 8) * 8;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        logic                 neg_x;
        logic                 neg_y;
    } side_t;

endpackage

FILE: rtl/segment_intersection_core.sv
// Top level of the 2D segment intersection pipeline.
// Depends on segi_pkg and segi_div.

// Takes one pair of segments per cycle and returns one result per pair, in order,
// through a delta stage, a product stage, a cross-product sum stage, a
// sign-normalise and range-test stage, a numerator scaling stage, one pipelined
// divider stage per quotient bit (CW of them) and the output register. The
// divider depth sets the latency; throughput is one request per clock. The whole
// pipe advances together and holds only while the output register is full and not
// taken. Parallel, collinear or degenerate segments report no hit; a miss returns
// zero coordinates.
module segment_intersection_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [segi_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // cross_x, cross_y
    output logic [segi_pkg::OUT_W-1:0] m_tdata,
    // hit
    output logic                       m_tuser
);
    import segi_pkg::*;

    logic en;

    // inputs as signed coordinates
    logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    assign ax0 = s_tdata[0*CW +: CW];
    assign ay0 = s_tdata[1*CW +: CW];
    assign ax1 = s_tdata[2*CW +: CW];
    assign ay1 = s_tdata[3*CW +: CW];
    assign bx0 = s_tdata[4*CW +: CW];
    assign by0 = s_tdata[5*CW +: CW];
    assign bx1 = s_tdata[6*CW +: CW];
    assign by1 = s_tdata[7*CW +: CW];

    // stage 1: direction vectors and start offset
    logic                 v1_reg;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, ox_reg, oy_reg;
    logic signed [CW-1:0] bx1_reg, by1_reg;

    // stage 2: six products
    logic                 v2_reg;
    logic signed [PW-1:0] pd1_reg, pd2_reg, ps1_reg, ps2_reg, pt1_reg, pt2_reg;
    logic signed [DW-1:0] e1x_reg, e1y_reg;
    logic signed [CW-1:0] bx2_reg, by2_reg;

    // stage 3: denominator and numerators
    logic                 v3_reg;
    logic signed [SW-1:0] den_reg, sn_reg, tn_reg;
    logic signed [DW-1:0] f1x_reg, f1y_reg;
    logic signed [CW-1:0] bx3_reg, by3_reg;

    // stage 4: sign-normalised values and hit
    logic                 v4_reg;
    logic [UW-1:0]        dn_reg, tnn_reg;
    logic [CW-1:0]        mx_reg, my_reg;
    side_t                sd4_reg;

    // stage 5: scaled numerators
    logic                 v5_reg;
    logic [NW-1:0]        nx_reg, ny_reg;
    logic [UW-1:0]        dn5_reg;
    side_t                sd5_reg;

    // output register
    logic                 out_v_reg;
    logic                 hit_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;

    assign en       = m_tready || !out_v_reg;
    assign s_tready = en;

    // normalisation, combinational part of stage 4
    logic                 neg_den;
    logic signed [SW-1:0] den_n, sn_n, tn_n;
    logic                 hit_n;
    logic signed [DW-1:0] abs_x, abs_y;

    always_comb
    begin
        neg_den = den_reg[SW-1];
        den_n   = neg_den ? -den_reg : den_reg;
        sn_n    = neg_den ? -sn_reg  : sn_reg;
        tn_n    = neg_den ? -tn_reg  : tn_reg;
        hit_n   = (den_n != '0) && !sn_n[SW-1] && !tn_n[SW-1]
                  && (sn_n <= den_n) && (tn_n <= den_n);
        abs_x   = f1x_reg[DW-1] ? -f1x_reg : f1x_reg;
        abs_y   = f1y_reg[DW-1] ? -f1y_reg : f1y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1x_reg <= DW'(ax1) - DW'(ax0);
            d1y_reg <= DW'(ay1) - DW'(ay0);
            d2x_reg <= DW'(bx1) - DW'(bx0);
            d2y_reg <= DW'(by1) - DW'(by0);
            ox_reg  <= DW'(ax0) - DW'(bx0);
            oy_reg  <= DW'(ay0) - DW'(by0);
            bx1_reg <= ax0;
            by1_reg <= ay0;

            pd1_reg <= PW'(d1x_reg) * PW'(d2y_reg);
            pd2_reg <= PW'(d2x_reg) * PW'(d1y_reg);
            ps1_reg <= PW'(d1x_reg) * PW'(oy_reg);
            ps2_reg <= PW'(d1y_reg) * PW'(ox_reg);
            pt1_reg <= PW'(d2x_reg) * PW'(oy_reg);
            pt2_reg <= PW'(d2y_reg) * PW'(ox_reg);
            e1x_reg <= d1x_reg;
            e1y_reg <= d1y_reg;
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;

            den_reg <= SW'(pd1_reg) - SW'(pd2_reg);
            sn_reg  <= SW'(ps1_reg) - SW'(ps2_reg);
            tn_reg  <= SW'(pt1_reg) - SW'(pt2_reg);
            f1x_reg <= e1x_reg;
            f1y_reg <= e1y_reg;
            bx3_reg <= bx2_reg;
            by3_reg <= by2_reg;

            dn_reg         <= UW'(den_n);
            tnn_reg        <= UW'(tn_n);
            mx_reg         <= abs_x[CW-1:0];
            my_reg         <= abs_y[CW-1:0];
            sd4_reg.hit    <= hit_n;
            sd4_reg.base_x <= bx3_reg;
            sd4_reg.base_y <= by3_reg;
            sd4_reg.neg_x  <= f1x_reg[DW-1];
            sd4_reg.neg_y  <= f1y_reg[DW-1];

            nx_reg  <= NW'(tnn_reg) * NW'(mx_reg);
            ny_reg  <= NW'(tnn_reg) * NW'(my_reg);
            dn5_reg <= dn_reg;
            sd5_reg <= sd4_reg;
        end
    end

    // quotient of tn*|d| by den, per axis
    logic          dv_valid;
    logic [QB-1:0] q_x, q_y;
    logic          fr_x, fr_y;
    side_t         dv_side;

    segi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .num_x     (nx_reg),
        .num_y     (ny_reg),
        .den       (dn5_reg),
        .in_side   (sd5_reg),
        .out_valid (dv_valid),
        .quo_x     (q_x),
        .quo_y     (q_y),
        .frac_x    (fr_x),
        .frac_y    (fr_y),
        .out_side  (dv_side)
    );

    // base +/- quotient, stepped back toward zero when a fraction was dropped
    logic signed [CW+1:0] vx, vy;
    logic signed [CW-1:0] cx_next, cy_next;

    always_comb
    begin
        if (!dv_side.neg_x)
        begin
            vx = (CW+2)'(dv_side.base_x) + $signed((CW+2)'(q_x));
            if (fr_x && vx[CW+1])
                vx = vx + (CW+2)'(1);
        end
        else
        begin
            vx = (CW+2)'(dv_side.base_x) - $signed((CW+2)'(q_x));
            if (fr_x && !vx[CW+1] && (vx != '0))
                vx = vx - (CW+2)'(1);
        end
        if (!dv_side.neg_y)
        begin
            vy = (CW+2)'(dv_side.base_y) + $signed((CW+2)'(q_y));
            if (fr_y && vy[CW+1])
                vy = vy + (CW+2)'(1);
        end
        else
        begin
            vy = (CW+2)'(dv_side.base_y) - $signed((CW+2)'(q_y));
            if (fr_y && !vy[CW+1] && (vy != '0))
                vy = vy - (CW+2)'(1);
        end
        cx_next = dv_side.hit ? vx[CW-1:0] : '0;
        cy_next = dv_side.hit ? vy[CW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= dv_side.hit;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = OUT_W'({cy_reg, cx_reg});

    // a miss always carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !hit_reg |-> (cx_reg == '0) && (cy_reg == '0))
        else $error("miss with nonzero point");
    // a hit needs a nonzero divisor and t within range
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && sd4_reg.hit |-> (dn_reg != '0) && (tnn_reg <= dn_reg))
        else $error("hit with bad range");
    // input is held off only while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> out_v_reg && !m_tready)
        else $error("input stalled without output back-pressure");

endmodule

FILE: rtl/segi_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage.
// Depends on segi_pkg.
module segi_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [segi_pkg::NW-1:0] num_x,
    input  logic [segi_pkg::NW-1:0] num_y,
    input  logic [segi_pkg::UW-1:0] den,
    input  segi_pkg::side_t         in_side,
    output logic                    out_valid,
    output logic [segi_pkg::QB-1:0] quo_x,
    output logic [segi_pkg::QB-1:0] quo_y,
    output logic                    frac_x,
    output logic                    frac_y,
    output segi_pkg::side_t         out_side
);
    import segi_pkg::*;

    logic          valid_reg [1:QB];
    logic [UW-1:0] rx_reg    [1:QB];
    logic [UW-1:0] ry_reg    [1:QB];
    logic [QB-1:0] lx_reg    [1:QB];
    logic [QB-1:0] ly_reg    [1:QB];
    logic [UW-1:0] d_reg     [1:QB];
    side_t         side_reg  [1:QB];

    logic          cv        [0:QB-1];
    logic [UW-1:0] crx       [0:QB-1];
    logic [UW-1:0] cry       [0:QB-1];
    logic [QB-1:0] clx       [0:QB-1];
    logic [QB-1:0] cly       [0:QB-1];
    logic [UW-1:0] cd        [0:QB-1];
    side_t         cs        [0:QB-1];

    logic          valid_next [1:QB];
    logic [UW-1:0] rx_next    [1:QB];
    logic [UW-1:0] ry_next    [1:QB];
    logic [QB-1:0] lx_next    [1:QB];
    logic [QB-1:0] ly_next    [1:QB];

    always_comb
    begin
        cv[0]  = in_valid;
        crx[0] = num_x[NW-1:QB];
        cry[0] = num_y[NW-1:QB];
        clx[0] = num_x[QB-1:0];
        cly[0] = num_y[QB-1:0];
        cd[0]  = den;
        cs[0]  = in_side;
        for (int i = 1; i < QB; i++)
        begin
            cv[i]  = valid_reg[i];
            crx[i] = rx_reg[i];
            cry[i] = ry_reg[i];
            clx[i] = lx_reg[i];
            cly[i] = ly_reg[i];
            cd[i]  = d_reg[i];
            cs[i]  = side_reg[i];
        end
    end

    // each stage shifts one dividend bit in and one quotient bit out
    always_comb
    begin
        logic [UW:0] tx;
        logic [UW:0] ty;
        tx = '0;
        ty = '0;
        for (int i = 0; i < QB; i++)
        begin
            tx = {crx[i], clx[i][QB-1]};
            ty = {cry[i], cly[i][QB-1]};
            valid_next[i+1] = cv[i];
            if (tx >= {1'b0, cd[i]})
            begin
                rx_next[i+1] = UW'(tx - {1'b0, cd[i]});
                lx_next[i+1] = {clx[i][QB-2:0], 1'b1};
            end
            else
            begin
                rx_next[i+1] = tx[UW-1:0];
                lx_next[i+1] = {clx[i][QB-2:0], 1'b0};
            end
            if (ty >= {1'b0, cd[i]})
            begin
                ry_next[i+1] = UW'(ty - {1'b0, cd[i]});
                ly_next[i+1] = {cly[i][QB-2:0], 1'b1};
            end
            else
            begin
                ry_next[i+1] = ty[UW-1:0];
                ly_next[i+1] = {cly[i][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= QB; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 1; i <= QB; i++)
                valid_reg[i] <= valid_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 1; i <= QB; i++)
            begin
                rx_reg[i]   <= rx_next[i];
                ry_reg[i]   <= ry_next[i];
                lx_reg[i]   <= lx_next[i];
                ly_reg[i]   <= ly_next[i];
                d_reg[i]    <= cd[i-1];
                side_reg[i] <= cs[i-1];
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign quo_x     = lx_reg[QB];
    assign quo_y     = ly_reg[QB];
    assign frac_x    = (rx_reg[QB] != '0);
    assign frac_y    = (ry_reg[QB] != '0);
    assign out_side  = side_reg[QB];

    // remainders stay below the divisor on every valid hit
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QB] && side_reg[QB].hit |-> rx_reg[QB] < d_reg[QB])
        else $error("x remainder not below divisor");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QB] && side_reg[QB].hit |-> ry_reg[QB] < d_reg[QB])
        else $error("y remainder not below divisor");
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg[QB]))
        else $error("divider moved while stalled");

endmodule
